>>> rtl/rmlb_pkg.sv
// shared constants and types for the row mirror line buffer
package rmlb_pkg;

    // row buffer sizing
    localparam int MAX_WIDTH   = 1024;
    localparam int POS_W       = $clog2(MAX_WIDTH);
    localparam int CNT_W       = $clog2(MAX_WIDTH + 1);
    localparam int BANK_ADDR_W = POS_W + 1;
    localparam int RAM_DEPTH   = 2 ** BANK_ADDR_W;

    // pixel and register widths
    localparam int PIXEL_W     = 24;
    localparam int ROW_WIDTH_W = 11;
    localparam int CMP_W       = (CNT_W > ROW_WIDTH_W) ? CNT_W : ROW_WIDTH_W;
    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    // apb register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_ROW_WIDTH = 3'd0;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // read request issued by the front with the ram read
    typedef struct packed {
        logic valid;
        logic last;
    } rd_req_t;

    // back side status seen by the front
    typedef struct packed {
        logic room;
    } back_status_t;

    // one mirrored pixel waiting for the output
    typedef struct packed {
        logic               last;
        logic [PIXEL_W-1:0] pixel;
    } pixel_beat_t;

endpackage

>>> rtl/rmlb_ram.sv
// generic simple dual port ram with registered read
module rmlb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/rmlb_fifo.sv
// small result queue between the ram read stage and the output
module rmlb_fifo
    import rmlb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  pixel_beat_t           push_data,
    input  logic                  pop,
    output pixel_beat_t           head,
    output logic                  not_empty,
    output logic [FIFO_CNT_W-1:0] count
);

    pixel_beat_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

`ifndef SYNTHESIS
    // credit scheme in the back must keep a free slot for every push
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("result queue underflow");
`endif

endmodule

>>> rtl/rmlb_back.sv
// back part: aligns ram read data with its tag, queues it and drives the output beat
module rmlb_back
    import rmlb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  rd_req_t             req,
    input  logic [PIXEL_W-1:0]  ram_rdata,
    output back_status_t        status,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PIXEL_W-1:0]  m_axis_tdata,
    output logic                m_axis_tlast
);

    logic                  s1_valid_reg;
    logic                  s1_last_reg;
    pixel_beat_t           push_data;
    pixel_beat_t           head;
    logic                  not_empty;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [FIFO_CNT_W:0]   committed;

    // ram data is valid in the cycle after the read was issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= req.last;
    end

    always_comb
    begin
        push_data.last  = s1_last_reg;
        push_data.pixel = ram_rdata;
    end

    assign pop = not_empty && m_axis_tready;

    rmlb_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    // queued beats plus the one in the read stage must leave a slot free
    assign committed   = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_valid_reg);
    assign status.room = (committed < (FIFO_CNT_W + 1)'(FIFO_DEPTH));

    assign m_axis_tvalid = not_empty;
    assign m_axis_tdata  = head.pixel;
    assign m_axis_tlast  = head.last;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |=> s1_valid_reg)
        else $error("read request lost before the result queue");
`endif

endmodule

>>> rtl/rmlb_front.sv
// front part: accepts input beats, keeps the fill and pending state, drives the ram ports
module rmlb_front
    import rmlb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [ROW_WIDTH_W-1:0] row_width,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [PIXEL_W-1:0]     s_axis_tdata,
    input  logic                   s_axis_tuser,
    input  back_status_t           status,
    output logic                   ram_we,
    output logic [BANK_ADDR_W-1:0] ram_waddr,
    output logic [PIXEL_W-1:0]     ram_wdata,
    output logic                   ram_re,
    output logic [BANK_ADDR_W-1:0] ram_raddr,
    output rd_req_t                req
);

    logic [POS_W-1:0] fill_position_reg;
    logic [POS_W-1:0] fill_position_next;
    logic             fill_bank_reg;
    logic             fill_bank_next;
    logic [CNT_W-1:0] pending_count_reg;
    logic [CNT_W-1:0] pending_count_next;

    logic             accept;
    logic             emit;
    logic             store;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W-1:0] pending_dec;
    logic [CNT_W-1:0] pos_inc;
    logic             row_full;

    // zero acts as one, anything beyond the buffer acts as the buffer size
    always_comb
    begin
        priority if (row_width == '0)
        begin
            width_eff = CNT_W'(1);
        end
        else if (CMP_W'(row_width) > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CNT_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = CNT_W'(CMP_W'(row_width));
        end
    end

    assign s_axis_tready = status.room;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign emit          = (pending_count_reg != '0);
    assign store         = !s_axis_tuser;
    assign pending_dec   = pending_count_reg - CNT_W'(1);
    assign pos_inc       = CNT_W'(fill_position_reg) + CNT_W'(1);
    assign row_full      = (pos_inc >= width_eff);

    // the emitted pixel comes from the completed bank, rightmost column first
    assign ram_re    = accept && emit;
    assign ram_raddr = {~fill_bank_reg, pending_dec[POS_W-1:0]};
    assign req.valid = ram_re;
    assign req.last  = (pending_count_reg == CNT_W'(1));

    assign ram_we    = accept && store;
    assign ram_waddr = {fill_bank_reg, fill_position_reg};
    assign ram_wdata = s_axis_tdata;

    always_comb
    begin
        fill_position_next = fill_position_reg;
        fill_bank_next     = fill_bank_reg;
        pending_count_next = pending_count_reg;
        if (accept)
        begin
            if (emit)
            begin
                pending_count_next = pending_dec;
            end
            if (store)
            begin
                if (row_full)
                begin
                    // swap banks, the whole completed row becomes pending
                    fill_bank_next     = ~fill_bank_reg;
                    fill_position_next = '0;
                    pending_count_next = width_eff;
                end
                else
                begin
                    fill_position_next = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_position_reg <= '0;
            fill_bank_reg     <= 1'b0;
            pending_count_reg <= '0;
        end
        else
        begin
            fill_position_reg <= fill_position_next;
            fill_bank_reg     <= fill_bank_next;
            pending_count_reg <= pending_count_next;
        end
    end

`ifndef SYNTHESIS
    // read and write of one beat always hit different banks
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_re && ram_we) |-> (ram_raddr[BANK_ADDR_W-1] != ram_waddr[BANK_ADDR_W-1]))
        else $error("read and write in the same bank");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg <= CNT_W'(MAX_WIDTH))
        else $error("pending count beyond buffer size");
`endif

endmodule

>>> rtl/row_mirror_line_buffer_top.sv
// top level of the row mirror line buffer
//
//  channel    | direction | beat contents
//  -----------+-----------+------------------------------------------------
//  s_axis     | in        | tdata red/green/blue, tuser drain
//  m_axis     | out       | tdata out_red/out_green/out_blue, tlast row_end
//  apb        | in        | row_width at address 0
//
// one input beat per cycle sustained while the result queue has room; a mirrored pixel
// passes the registered ram read and then the result queue before it leaves
// the ping-pong row ram takes one write and one read per cycle, which sets the rate
// reset clears fill position, fill bank, pending count and the queue; the ram
// holds garbage until rows are written, and no clearing pass is run
// when m_axis stalls the result queue fills and s_axis tready drops once only
// the in-flight read still has a free slot
module row_mirror_line_buffer_top
    import rmlb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input pixel beat
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PIXEL_W-1:0]  s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                s_axis_tuser,   // drain
    // mirrored pixel beat
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PIXEL_W-1:0]  m_axis_tdata,   // out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                m_axis_tlast,   // row_end
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic                   cfg_write;

    back_status_t           status;
    rd_req_t                req;
    logic                   ram_we;
    logic [BANK_ADDR_W-1:0] ram_waddr;
    logic [PIXEL_W-1:0]     ram_wdata;
    logic                   ram_re;
    logic [BANK_ADDR_W-1:0] ram_raddr;
    logic [PIXEL_W-1:0]     ram_rdata;

    // register port, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_ROW_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_write)
        begin
            row_width_reg <= pwdata[ROW_WIDTH_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_ROW_WIDTH) ? PDATA_W'(row_width_reg) : '0;

    // front: handshake, fill and pending bookkeeping, ram addressing
    rmlb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .row_width     (row_width_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .status        (status),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .req           (req)
    );

    // two row banks, bank select in the top address bit
    rmlb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_row_banks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // back: read stage, result queue and output beat
    rmlb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .ram_rdata     (ram_rdata),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
